[rtl/core/mk_pkg.sv]
`timescale 1ns / 1ps

package mk_pkg;

  // Keyer phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2,
    PH_GAP   = 2'd3
  } mk_phase_t;

  // Item commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Register map
  localparam int unsigned    CFG_ADDR_W     = 3;
  localparam int unsigned    CFG_DATA_W     = 32;
  localparam logic           REG_UNIT_TICKS = 1'b0;
  localparam logic [15:0]    UNIT_TICKS_RST = 16'd100;

  // Unit counts
  localparam logic [2:0] DASH_UNITS = 3'd3;
  localparam logic [2:0] DOT_UNITS  = 3'd1;
  localparam logic [2:0] SPACE_UNITS = 3'd1;
  localparam logic [2:0] GAP_UNITS  = 3'd4;

  // Character ranges
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Pattern bytes: elements in [7:3], MSB first (1 = dash), count in [2:0]
  localparam logic [7:0] ALPHA_CODE [26] = '{
    8'h42, 8'h84, 8'hA4, 8'h83, 8'h01, 8'h24, 8'hC3, 8'h04, 8'h02, 8'h74,
    8'hA3, 8'h44, 8'hC2, 8'h82, 8'hE3, 8'h64, 8'hD4, 8'h43, 8'h03, 8'h81,
    8'h23, 8'h14, 8'h63, 8'h94, 8'hB4, 8'hC4
  };

  // '/' then '0' to '9'
  localparam logic [7:0] DIGIT_CODE [11] = '{
    8'h95, 8'hFD, 8'h7D, 8'h3D, 8'h1D, 8'h0D, 8'h05, 8'h85, 8'hC5, 8'hE5,
    8'hF5
  };

  typedef struct packed {
    logic [7:0] code;
    logic       known;
  } mk_lookup_t;

  typedef struct packed {
    logic key;
    logic busy;
    logic rejected;
    logic unknown_char;
  } mk_result_t;

endpackage

[rtl/core/mk_lookup.sv]
`timescale 1ns / 1ps

module mk_lookup import mk_pkg::*; (
  input  logic [7:0] character,
  output mk_lookup_t lookup
);

  logic [7:0] alpha_off;
  logic [7:0] digit_off;

  assign alpha_off = character - CHAR_A;
  assign digit_off = character - CHAR_SLASH;

  always_comb begin
    lookup.code  = 8'h00;
    lookup.known = 1'b1;
    priority if (character == CHAR_NUL || character == CHAR_SPACE) begin
      lookup.code = 8'h00;
    end else if (character >= CHAR_A && character <= CHAR_Z) begin
      lookup.code = ALPHA_CODE[alpha_off[4:0]];
    end else if (character >= CHAR_SLASH && character <= CHAR_NINE) begin
      lookup.code = DIGIT_CODE[digit_off[3:0]];
    end else begin
      lookup.known = 1'b0;
    end
  end

endmodule

[rtl/core/mk_seq.sv]
`timescale 1ns / 1ps

module mk_seq import mk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        command,
  input  mk_lookup_t  lookup,
  input  logic [15:0] unit_ticks,
  output mk_result_t  result
);

  mk_phase_t   phase_r,   phase_nxt;
  logic [4:0]  pattern_r, pattern_nxt;
  logic [2:0]  elems_r,   elems_nxt;
  logic [2:0]  units_r,   units_nxt;
  logic [15:0] tick_r,    tick_nxt;

  logic [16:0] tick_inc;
  logic [2:0]  units_dec;
  logic [2:0]  elems_dec;
  logic [4:0]  pattern_shl;

  assign tick_inc    = {1'b0, tick_r} + 17'd1;
  assign units_dec   = units_r - 3'd1;
  assign elems_dec   = elems_r - 3'd1;
  assign pattern_shl = {pattern_r[3:0], 1'b0};

  // Next state
  always_comb begin
    phase_nxt   = phase_r;
    pattern_nxt = pattern_r;
    elems_nxt   = elems_r;
    units_nxt   = units_r;
    tick_nxt    = tick_r;
    if (fire) begin
      if (command == CMD_LOAD) begin
        if (phase_r == PH_IDLE) begin
          pattern_nxt = lookup.code[7:3];
          elems_nxt   = lookup.code[2:0];
          tick_nxt    = '0;
          if (lookup.code[2:0] != 3'd0) begin
            phase_nxt = PH_MARK;
            units_nxt = lookup.code[7] ? DASH_UNITS : DOT_UNITS;
          end else begin
            phase_nxt = PH_GAP;
            units_nxt = GAP_UNITS;
          end
        end
      end else if (phase_r != PH_IDLE) begin
        if (tick_inc < {1'b0, unit_ticks}) begin
          tick_nxt = tick_inc[15:0];
        end else begin
          tick_nxt  = '0;
          units_nxt = units_dec;
          if (units_dec == 3'd0) begin
            unique case (phase_r)
              PH_MARK: begin
                phase_nxt = PH_SPACE;
                units_nxt = SPACE_UNITS;
              end
              PH_SPACE: begin
                pattern_nxt = pattern_shl;
                elems_nxt   = elems_dec;
                if (elems_dec != 3'd0) begin
                  phase_nxt = PH_MARK;
                  units_nxt = pattern_r[3] ? DASH_UNITS : DOT_UNITS;
                end else begin
                  phase_nxt = PH_GAP;
                  units_nxt = GAP_UNITS;
                end
              end
              PH_GAP: begin
                phase_nxt = PH_IDLE;
              end
              default: begin
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
      end
    end
  end

  // Result: key, busy from the state the item leaves behind
  always_comb begin
    result.key          = (phase_nxt == PH_MARK);
    result.busy         = (phase_nxt != PH_IDLE);
    result.rejected     = (command == CMD_LOAD) && (phase_r != PH_IDLE);
    result.unknown_char = (command == CMD_LOAD) && (phase_r == PH_IDLE) && !lookup.known;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pattern_r <= '0;
      elems_r   <= '0;
      units_r   <= '0;
      tick_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      pattern_r <= pattern_nxt;
      elems_r   <= elems_nxt;
      units_r   <= units_nxt;
      tick_r    <= tick_nxt;
    end
  end

endmodule

[rtl/core/morse_keyer_core.sv]
`timescale 1ns / 1ps
// Path: an accepted input transaction is held in the input register, and its result in the result register.
// Throughput: one item per cycle while results are taken; the input register and the result register
//   are parted, so a new item is taken while a finished result waits.
// Reset: synchronous, active low; keyer idle, counters cleared, unit_ticks = 100,
//   no transaction held in either register.

module morse_keyer_core import mk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [7:0]            in_character,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_key,
  output logic                  out_busy_res,
  output logic                  out_rejected,
  output logic                  out_unknown_char,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration register
  logic [15:0] unit_ticks_r;
  logic        cfg_wr;
  logic        reg_idx;

  // Input register
  logic        in_vld_r;
  logic        in_cmd_r;
  logic [7:0]  in_char_r;

  // Result register
  logic        out_vld_r;
  mk_result_t  out_res_r;

  logic        proc_fire;
  mk_lookup_t  lookup;
  mk_result_t  result;

  // ---------------------------------------------------------------------------
  // APB: no wait states; the register index is the word address
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_UNIT_TICKS);

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_UNIT_TICKS) begin
      prdata = {{(CFG_DATA_W-16){1'b0}}, unit_ticks_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_TICKS_RST;
    end else if (cfg_wr) begin
      unit_ticks_r <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: process the held item whenever the result register is free
  // or its transaction completes this cycle; refill the input register behind it.
  // ---------------------------------------------------------------------------
  assign proc_fire = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // Payload: hold while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r  <= in_command;
      in_char_r <= in_character;
    end
  end

  // ---------------------------------------------------------------------------
  // Character table and keying sequencer
  // ---------------------------------------------------------------------------
  mk_lookup u_lookup (
    .character (in_char_r),
    .lookup    (lookup)
  );

  mk_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (proc_fire),
    .command    (in_cmd_r),
    .lookup     (lookup),
    .unit_ticks (unit_ticks_r),
    .result     (result)
  );

  // ---------------------------------------------------------------------------
  // Result register: load on every processed item, drop valid once taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_res_r <= result;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_key          = out_res_r.key;
  assign out_busy_res     = out_res_r.busy;
  assign out_rejected     = out_res_r.rejected;
  assign out_unknown_char = out_res_r.unknown_char;

`ifndef NO_ASSERTIONS
  // A keyed output only ever comes while a character is in progress
  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (!out_res_r.key || out_res_r.busy))
    else $error("key asserted while keyer idle");

  // A dropped load never also reports an unknown character
  a_rej_unk: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_res_r.rejected && out_res_r.unknown_char))
    else $error("rejected and unknown_char both set");

  // Both registers full and result stalled: no further input transaction
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && !out_ready) |-> !in_ready)
    else $error("input taken with full pipeline");

  // A processed item always leaves a valid result behind
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire |=> out_vld_r)
    else $error("processed item lost its result");
`endif

endmodule
